// ===== sv/jac_pkg.sv =====
// shared types and constants of the joystick axis conditioner
package jac_pkg;

   // channel and register widths
   localparam int RAW_W    = 12;
   localparam int SPEED_W  = 8;
   localparam int DRIVE_W  = 9;
   localparam int OFF_W    = 12;
   localparam int SMOOTH_W = 10;
   localparam int CSR_W    = 12;
   localparam int NUM_LANES = 2;
   localparam int NUM_STAGES = 4;

   // offset clamp and map span
   localparam logic signed [12:0] OFFSET_LIMIT = 13'sd1295;
   localparam logic signed [10:0] MAP_SPAN     = 11'sd323;

   // reciprocal of ten: (m * 6554) >> 16 is exact for m up to 3700
   localparam logic [12:0] DIV10_MUL   = 13'd6554;
   localparam int          DIV10_SHIFT = 16;

   // reciprocal of 323: (m * 415535) >> 27 is exact for m up to 2^18
   localparam logic [18:0] DIV323_MUL   = 19'd415535;
   localparam int          DIV323_SHIFT = 27;

   // register reset values
   localparam logic [RAW_W-1:0]   CENTER_RESET    = 12'd2800;
   localparam logic [RAW_W-1:0]   DEAD_ZONE_RESET = 12'd300;
   localparam logic [SPEED_W-1:0] SPEED_RESET     = 8'd125;

   // register indexes
   typedef enum logic [1:0] {
      CSR_CENTER    = 2'd0,
      CSR_DEAD_ZONE = 2'd1,
      CSR_SPEED     = 2'd2
   } csr_index_type;

   // per-stage load strobes shared by all lanes
   typedef struct packed {
      logic [NUM_STAGES-1:0] load;
   } stage_ctrl_type;

   // what one lane hands the merging stage
   typedef struct packed {
      logic signed [DRIVE_W-1:0] drive;
      logic                      at_limit;
   } lane_result_type;

endpackage

// ===== sv/jac_axis_lane.sv =====
// one axis lane: dead zone, clamp, smoother, linear map and drive clamp
module jac_axis_lane (
   input  logic                           clock,
   input  logic                           reset,
   input  jac_pkg::stage_ctrl_type        ctrl,
   input  logic [jac_pkg::RAW_W-1:0]      raw,
   input  logic [jac_pkg::RAW_W-1:0]      center,
   input  logic [jac_pkg::RAW_W-1:0]      dead_zone,
   input  logic [jac_pkg::SPEED_W-1:0]    speed,
   output jac_pkg::lane_result_type       result
);

   logic signed [12:0] off_full;
   logic [11:0]        off_mag;
   logic signed [11:0] off_in;
   logic signed [11:0] off_ff;

   logic signed [12:0] sum;
   logic [11:0]        sum_mag;
   logic [24:0]        div10_prod;
   logic [8:0]         div10_q;
   logic signed [9:0]  smooth_in;
   logic signed [9:0]  smooth_ff;

   logic signed [10:0] biased;
   logic [9:0]         biased_mag;
   logic               neg_in;
   logic [17:0]        scaled_in;
   logic               neg_ff;
   logic [17:0]        scaled_ff;

   logic [36:0]        div323_prod;
   logic [9:0]         div323_q;
   logic signed [10:0] quo_in;
   logic signed [10:0] quo_ff;

   logic signed [10:0] spd;
   logic signed [10:0] level;
   logic               hit_hi;
   logic               hit_lo;
   logic signed [10:0] level_clamped;
   logic signed [10:0] drive_full;

   // stage 1: center offset, dead zone and clamp
   always_comb begin
      off_full = $signed({1'b0, raw}) - $signed({1'b0, center});
      off_mag  = off_full[12] ? 12'(-off_full) : off_full[11:0];
      if (off_mag < dead_zone) begin
         off_in = '0;
      end else if (off_full > jac_pkg::OFFSET_LIMIT) begin
         off_in = 12'(jac_pkg::OFFSET_LIMIT);
      end else if (off_full < -jac_pkg::OFFSET_LIMIT) begin
         off_in = 12'(-jac_pkg::OFFSET_LIMIT);
      end else begin
         off_in = off_full[11:0];
      end
   end

   // stage 2: leaky smoother, (3s + 2x) / 10 toward zero
   always_comb begin
      sum = 13'({{3{smooth_ff[9]}}, smooth_ff})
          + 13'({{2{smooth_ff[9]}}, smooth_ff, 1'b0})
          + 13'({off_ff, 1'b0});
      sum_mag    = sum[12] ? 12'(-sum) : sum[11:0];
      div10_prod = 25'(sum_mag) * 25'(jac_pkg::DIV10_MUL);
      div10_q    = div10_prod[jac_pkg::DIV10_SHIFT +: 9];
      smooth_in  = sum[12] ? -$signed({1'b0, div10_q}) : $signed({1'b0, div10_q});
   end

   // stage 3: shift by the span and scale by speed
   always_comb begin
      biased     = $signed({smooth_ff[9], smooth_ff}) + jac_pkg::MAP_SPAN;
      neg_in     = biased[10];
      biased_mag = biased[10] ? 10'(-biased) : biased[9:0];
      scaled_in  = 18'(biased_mag) * 18'(speed);
   end

   // stage 4: divide by the span
   always_comb begin
      div323_prod = 37'(scaled_ff) * 37'(jac_pkg::DIV323_MUL);
      div323_q    = div323_prod[jac_pkg::DIV323_SHIFT +: 10];
      quo_in      = neg_ff ? -$signed({1'b0, div323_q}) : $signed({1'b0, div323_q});
   end

   // output: remove speed, clamp to plus or minus speed, negate
   always_comb begin
      spd    = $signed({3'b000, speed});
      level  = quo_ff - spd;
      hit_hi = (level >= spd);
      hit_lo = (level <= -spd);
      if (hit_hi) begin
         level_clamped = spd;
      end else if (hit_lo) begin
         level_clamped = -spd;
      end else begin
         level_clamped = level;
      end
      drive_full      = -level_clamped;
      result.drive    = drive_full[jac_pkg::DRIVE_W-1:0];
      result.at_limit = hit_hi | hit_lo;
   end

   // smoother state
   always_ff @(posedge clock) begin
      if (reset) begin
         smooth_ff <= '0;
      end else if (ctrl.load[1]) begin
         smooth_ff <= smooth_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (ctrl.load[0]) begin
         off_ff <= off_in;
      end
      if (ctrl.load[2]) begin
         neg_ff    <= neg_in;
         scaled_ff <= scaled_in;
      end
      if (ctrl.load[3]) begin
         quo_ff <= quo_in;
      end
   end

endmodule

// ===== sv/jac_merge.sv =====
// merging stage: combines the lane results into the registered result item
module jac_merge (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   input  jac_pkg::lane_result_type              lane_x,
   input  jac_pkg::lane_result_type              lane_y,
   input  logic                                  pressed,
   output logic                                  in_ready,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [jac_pkg::DRIVE_W-1:0]    rsp_drive_x,
   output logic signed [jac_pkg::DRIVE_W-1:0]    rsp_drive_y,
   output logic                                  rsp_pressed,
   output logic                                  rsp_at_max
);

   logic                              valid_ff;
   logic                              load;
   logic signed [jac_pkg::DRIVE_W-1:0] drive_x_ff;
   logic signed [jac_pkg::DRIVE_W-1:0] drive_y_ff;
   logic                              pressed_ff;
   logic                              at_max_ff;
   logic                              at_max_in;

   // output register frees when empty or when the item leaves
   assign in_ready  = !valid_ff || !rsp_stall;
   assign load      = in_ready && in_valid;
   assign at_max_in = lane_x.at_limit | lane_y.at_limit;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (load) begin
         drive_x_ff <= lane_x.drive;
         drive_y_ff <= lane_y.drive;
         pressed_ff <= pressed;
         at_max_ff  <= at_max_in;
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_drive_x = drive_x_ff;
   assign rsp_drive_y = drive_y_ff;
   assign rsp_pressed = pressed_ff;
   assign rsp_at_max  = at_max_ff;

endmodule

// ===== sv/joystick_axis_conditioner_core.sv =====
// top level of the joystick axis conditioner: registers, lane control and lanes
//
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_stall  | raw_x, raw_y, button_level
//  rsp     | out       | rsp_valid/rsp_stall  | drive_x, drive_y, pressed, at_max
//  csr     | in        | csr_write            | csr_index, csr_data
//
// one item per cycle sustained while rsp_stall is low; an accepted sample passes through
// four lane stages and then the output register (the first loaded at acceptance) before
// rsp_valid rises. the smoother update in stage two is the only loop. reset is
// synchronous and clears the smoother state, the pipeline valid bits and the registers
// to their defaults. each stage moves forward when the stage after it is empty or
// moving, so bubbles close up under rsp_stall and req_stall rises only when the whole
// pipe is full.
module joystick_axis_conditioner_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [jac_pkg::RAW_W-1:0]            req_raw_x,
   input  logic [jac_pkg::RAW_W-1:0]            req_raw_y,
   input  logic                                 req_button_level,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [jac_pkg::DRIVE_W-1:0]   rsp_drive_x,
   output logic signed [jac_pkg::DRIVE_W-1:0]   rsp_drive_y,
   output logic                                 rsp_pressed,
   output logic                                 rsp_at_max,
   input  logic                                 csr_write,
   input  logic [1:0]                           csr_index,
   input  logic [jac_pkg::CSR_W-1:0]            csr_data
);

   localparam int NS = jac_pkg::NUM_STAGES;

   logic [jac_pkg::RAW_W-1:0]   center_ff;
   logic [jac_pkg::RAW_W-1:0]   dead_zone_ff;
   logic [jac_pkg::SPEED_W-1:0] speed_ff;

   logic [NS-1:0]   valid_ff;
   logic [NS-1:0]   pressed_ff;
   logic [NS:0]     ready;
   logic [NS-1:0]   upstream;
   logic            merge_ready;
   jac_pkg::stage_ctrl_type     ctrl;
   jac_pkg::lane_result_type    lane_res [jac_pkg::NUM_LANES];
   logic [jac_pkg::RAW_W-1:0]   lane_raw [jac_pkg::NUM_LANES];

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         center_ff    <= jac_pkg::CENTER_RESET;
         dead_zone_ff <= jac_pkg::DEAD_ZONE_RESET;
         speed_ff     <= jac_pkg::SPEED_RESET;
      end else if (csr_write) begin
         case (csr_index)
            jac_pkg::CSR_CENTER:    center_ff    <= csr_data[jac_pkg::RAW_W-1:0];
            jac_pkg::CSR_DEAD_ZONE: dead_zone_ff <= csr_data[jac_pkg::RAW_W-1:0];
            jac_pkg::CSR_SPEED:     speed_ff     <= csr_data[jac_pkg::SPEED_W-1:0];
            default: ;
         endcase
      end
   end

   // stage ready chain and load strobes
   always_comb begin
      ready[NS] = merge_ready;
      for (int k = NS - 1; k >= 0; k--) begin
         ready[k] = !valid_ff[k] || ready[k+1];
      end
      upstream = {valid_ff[NS-2:0], req_valid};
      for (int k = 0; k < NS; k++) begin
         ctrl.load[k] = ready[k] && upstream[k];
      end
   end

   assign req_stall = !ready[0];

   // pipeline valid bits and button flag
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < NS; k++) begin
            if (ready[k]) begin
               valid_ff[k] <= upstream[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[0]) begin
         pressed_ff[0] <= !req_button_level;
      end
      for (int k = 1; k < NS; k++) begin
         if (ctrl.load[k]) begin
            pressed_ff[k] <= pressed_ff[k-1];
         end
      end
   end

   // axis lanes
   assign lane_raw[0] = req_raw_x;
   assign lane_raw[1] = req_raw_y;

   for (genvar g = 0; g < jac_pkg::NUM_LANES; g++) begin : g_lane
      jac_axis_lane u_lane (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .raw       (lane_raw[g]),
         .center    (center_ff),
         .dead_zone (dead_zone_ff),
         .speed     (speed_ff),
         .result    (lane_res[g])
      );
   end

   // merge and output register
   jac_merge u_merge (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (valid_ff[NS-1]),
      .lane_x      (lane_res[0]),
      .lane_y      (lane_res[1]),
      .pressed     (pressed_ff[NS-1]),
      .in_ready    (merge_ready),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_drive_x (rsp_drive_x),
      .rsp_drive_y (rsp_drive_y),
      .rsp_pressed (rsp_pressed),
      .rsp_at_max  (rsp_at_max)
   );

endmodule

// ===== dv/joystick_axis_conditioner_core_tb.sv =====
// testbench for the joystick axis conditioner: directed and random samples vs a predictor
module joystick_axis_conditioner_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // register index that no register answers to
   localparam logic [1:0] CSR_UNUSED = 2'd3;
   localparam int RAW_MAX = 4095;
   localparam int OFFSET_CLAMP = 1295;
   localparam int SPAN = 323;
   localparam int DRAIN_CYCLES = 10;

   typedef struct {
      logic signed [jac_pkg::DRIVE_W-1:0] drive_x;
      logic signed [jac_pkg::DRIVE_W-1:0] drive_y;
      logic                               pressed;
      logic                               at_max;
   } drive_item_type;

   // predicts drive commands from accepted samples and checks rsp items in order
   class drive_predictor;
      int center;
      int dead_zone;
      int speed;
      int smooth[2];
      int mismatches;
      drive_item_type expected_drives[$];

      function new();
         center = 2800;
         dead_zone = 300;
         speed = 125;
         smooth[0] = 0;
         smooth[1] = 0;
         mismatches = 0;
      endfunction

      task report(input string msg);
         $display("%0t ns: mismatch: %s", $time, msg);
         mismatches++;
      endtask

      function void write_register(input logic [1:0] idx, input logic [jac_pkg::CSR_W-1:0] data);
         case (idx)
            jac_pkg::CSR_CENTER: begin
               center = int'(data);
            end
            jac_pkg::CSR_DEAD_ZONE: begin
               dead_zone = int'(data);
            end
            jac_pkg::CSR_SPEED: begin
               speed = int'(data[jac_pkg::SPEED_W-1:0]);
            end
            default: begin
            end
         endcase
      endfunction

      // center, dead zone, clamp, smoother, map, clamp and negate for one axis
      function int axis_drive(input int lane, input int raw);
         int off;
         int mag;
         int s;
         int v;
         off = raw - center;
         mag = (off < 0) ? -off : off;
         if (mag < dead_zone) off = 0;
         if (off > OFFSET_CLAMP) off = OFFSET_CLAMP;
         if (off < -OFFSET_CLAMP) off = -OFFSET_CLAMP;
         s = (3 * smooth[lane] + 2 * off) / 10;
         smooth[lane] = s;
         v = ((s + SPAN) * 2 * speed) / (2 * SPAN) - speed;
         if (v > speed) v = speed;
         if (v < -speed) v = -speed;
         return -v;
      endfunction

      function void note_sample(input logic [jac_pkg::RAW_W-1:0] raw_x,
                                input logic [jac_pkg::RAW_W-1:0] raw_y,
                                input logic button_level);
         drive_item_type item;
         int dx;
         int dy;
         dx = axis_drive(0, int'(raw_x));
         dy = axis_drive(1, int'(raw_y));
         item.drive_x = dx[jac_pkg::DRIVE_W-1:0];
         item.drive_y = dy[jac_pkg::DRIVE_W-1:0];
         item.pressed = ~button_level;
         item.at_max = (dx == speed || dx == -speed || dy == speed || dy == -speed);
         expected_drives.push_back(item);
      endfunction

      task check_drive(input drive_item_type got);
         drive_item_type want;
         if (expected_drives.size() == 0) begin
            report("rsp item with nothing expected");
         end else begin
            want = expected_drives.pop_front();
            if (got.drive_x !== want.drive_x)
               report($sformatf("drive_x got %0d want %0d", got.drive_x, want.drive_x));
            if (got.drive_y !== want.drive_y)
               report($sformatf("drive_y got %0d want %0d", got.drive_y, want.drive_y));
            if (got.pressed !== want.pressed)
               report($sformatf("pressed got %b want %b", got.pressed, want.pressed));
            if (got.at_max !== want.at_max)
               report($sformatf("at_max got %b want %b", got.at_max, want.at_max));
         end
      endtask
   endclass

   logic                               clock;
   logic                               reset;
   logic                               req_valid;
   logic                               req_stall;
   logic [jac_pkg::RAW_W-1:0]          req_raw_x;
   logic [jac_pkg::RAW_W-1:0]          req_raw_y;
   logic                               req_button_level;
   logic                               rsp_valid;
   logic                               rsp_stall;
   logic signed [jac_pkg::DRIVE_W-1:0] rsp_drive_x;
   logic signed [jac_pkg::DRIVE_W-1:0] rsp_drive_y;
   logic                               rsp_pressed;
   logic                               rsp_at_max;
   logic                               csr_write;
   logic [1:0]                         csr_index;
   logic [jac_pkg::CSR_W-1:0]          csr_data;

   drive_predictor drives;
   int send_idle_pct;
   int stall_pct;

   joystick_axis_conditioner_core u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_raw_x        (req_raw_x),
      .req_raw_y        (req_raw_y),
      .req_button_level (req_button_level),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_drive_x      (rsp_drive_x),
      .rsp_drive_y      (rsp_drive_y),
      .rsp_pressed      (rsp_pressed),
      .rsp_at_max       (rsp_at_max),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   // clock
   always #2 clock = ~clock;

   // random receiver stall
   always @(negedge clock) begin
      rsp_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
   end

   // rsp monitor
   always @(posedge clock) begin
      drive_item_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.drive_x = rsp_drive_x;
         got.drive_y = rsp_drive_y;
         got.pressed = rsp_pressed;
         got.at_max = rsp_at_max;
         drives.check_drive(got);
      end
   end

   // send one sample, with random idle cycles ahead of it
   task automatic send_sample(input int raw_x, input int raw_y, input logic button_level);
      int gap;
      gap = 0;
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) gap++;
      if (gap != 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_raw_x <= raw_x[jac_pkg::RAW_W-1:0];
      req_raw_y <= raw_y[jac_pkg::RAW_W-1:0];
      req_button_level <= button_level;
      do @(posedge clock); while (req_stall);
      drives.note_sample(raw_x[jac_pkg::RAW_W-1:0], raw_y[jac_pkg::RAW_W-1:0], button_level);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [jac_pkg::CSR_W-1:0] data);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      drives.write_register(idx, data);
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   // stop sending and wait until every expected item has come out
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (drives.expected_drives.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // new register setting, written while the pipe is empty
   task automatic apply_setting(input int center, input int dead_zone,
                                input logic [jac_pkg::CSR_W-1:0] speed_data);
      drain();
      write_csr(jac_pkg::CSR_CENTER, center[jac_pkg::CSR_W-1:0]);
      write_csr(jac_pkg::CSR_DEAD_ZONE, dead_zone[jac_pkg::CSR_W-1:0]);
      write_csr(jac_pkg::CSR_SPEED, speed_data);
      write_csr(CSR_UNUSED, jac_pkg::CSR_W'($urandom));
   endtask

   // one raw axis value: uniform, rail, around the center, or held
   function automatic int pick_raw(input int prev);
      int kind;
      int span;
      int v;
      kind = $urandom_range(9);
      if (kind <= 2) begin
         v = $urandom_range(RAW_MAX);
      end else if (kind <= 4) begin
         v = $urandom_range(1) ? RAW_MAX - $urandom_range(1) : $urandom_range(1);
      end else if (kind <= 7) begin
         span = drives.dead_zone + 20;
         v = drives.center + int'($urandom_range(2 * span)) - span;
      end else begin
         v = prev;
      end
      if (v < 0) v = 0;
      if (v > RAW_MAX) v = RAW_MAX;
      return v;
   endfunction

   // run limit
   initial begin
      #(2_000_000);
      $display("Verification failed");
      $finish;
   end

   initial begin
      int prev_x;
      int prev_y;
      int speed_sel;
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_raw_x = '0;
      req_raw_y = '0;
      req_button_level = 1'b1;
      rsp_stall = 1'b0;
      csr_write = 1'b0;
      csr_index = jac_pkg::CSR_CENTER;
      csr_data = '0;
      send_idle_pct = 0;
      stall_pct = 0;
      drives = new();
      prev_x = 2800;
      prev_y = 2800;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: rails into saturation, center, dead zone edges
      send_sample(0, RAW_MAX, 1'b0);
      send_sample(RAW_MAX, 0, 1'b1);
      send_sample(0, RAW_MAX, 1'b0);
      send_sample(0, RAW_MAX, 1'b0);
      send_sample(2800, 2800, 1'b1);
      send_sample(3099, 2501, 1'b0);
      send_sample(3100, 2500, 1'b1);
      send_sample(2500, 3100, 1'b1);

      // lowest center, no dead zone, full speed
      apply_setting(0, 0, 12'h0ff);
      send_sample(0, 0, 1'b1);
      send_sample(RAW_MAX, RAW_MAX, 1'b0);
      send_sample(RAW_MAX, RAW_MAX, 1'b0);
      send_sample(RAW_MAX, RAW_MAX, 1'b1);
      send_sample(1, 4094, 1'b1);

      // highest center and dead zone, slowest nonzero speed
      apply_setting(RAW_MAX, RAW_MAX, 12'hf01);
      send_sample(0, RAW_MAX, 1'b0);
      send_sample(0, 1, 1'b1);
      send_sample(0, 0, 1'b0);
      send_sample(4094, RAW_MAX, 1'b1);

      // speed zero: both drives zero and at_max set
      apply_setting(2048, 100, 12'h100);
      send_sample(0, RAW_MAX, 1'b0);
      send_sample(2048, 2048, 1'b1);
      send_sample(RAW_MAX, 0, 1'b1);

      // random segments over idle modes and register settings
      for (int seg = 0; seg < 8; seg++) begin
         case (seg)
            0: apply_setting(2800, 300, 12'd125);
            1: apply_setting(0, 0, 12'hfff);
            2: apply_setting(RAW_MAX, RAW_MAX, 12'd1);
            default: begin
               speed_sel = $urandom_range(1, 255);
               apply_setting($urandom_range(RAW_MAX), $urandom_range(800),
                             {4'($urandom), speed_sel[7:0]});
            end
         endcase
         case (seg % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 83; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 83; end
            default: begin send_idle_pct = 31; stall_pct = 31; end
         endcase
         for (int n = 0; n < 50; n++) begin
            prev_x = pick_raw(prev_x);
            prev_y = pick_raw(prev_y);
            send_sample(prev_x, prev_y, 1'($urandom));
         end
      end

      drain();
      while (drives.expected_drives.size() != 0) begin
         void'(drives.expected_drives.pop_front());
         drives.report("expected item never came out");
      end
      if (drives.mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
sv/jac_pkg.sv
sv/jac_axis_lane.sv
sv/jac_merge.sv
sv/joystick_axis_conditioner_core.sv
dv/joystick_axis_conditioner_core_tb.sv
